>>> rtl/i2cms_pkg.sv
// Package with the types, constants and codes of the I2C master transfer sequencer.
package i2cms_pkg;

    localparam int BUFFER_DEPTH = 16;
    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int POS_W  = 16;
    localparam int CALC_W = (POS_W > 8) ? POS_W : 8;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_EVENT = 2'd2,
        FUNC_ERROR = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_ACK_FAIL = 2'd1,
        ERR_BUS      = 2'd2
    } t_err;

    localparam int ST_START_SENT = 0;
    localparam int ST_ADDR       = 1;
    localparam int ST_TRANSMIT   = 2;
    localparam int ST_TX_EMPTY   = 3;
    localparam int ST_BYTE_DONE  = 4;
    localparam int ST_RX_FULL    = 5;
    localparam int ST_ACK_FAIL   = 6;

    typedef struct packed {
        t_func      func;
        logic [6:0] dev_addr;
        logic       is_read;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
        logic [3:0] byte_index;
        logic [6:0] status_flags;
    } t_in_item;

    typedef struct packed {
        logic       dr_write;
        logic [7:0] dr_data;
        logic       start_req;
        logic       stop_req;
        logic       ack_bit;
        logic       busy_res;
        logic       op_done;
        logic       start_rejected;
        t_err       error_code;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic [3:0] rx_index;
    } t_out_item;

endpackage

>>> rtl/i2c_master_transfer_sequencer_unit.sv
// Top level of the I2C master transfer sequencer: event decoding and transfer buffer.
//
// The sequencer takes one transaction per clock cycle, back to back, and delivers its
// result in the cycle after acceptance through a single output register; a new transaction
// is taken whenever that register is empty or is being emptied in the same cycle. The
// transfer buffer is a 16 x 8 synchronous memory with one write and one read port: the
// decision logic settles all scalar state at acceptance and issues the buffer read then,
// and the read data fills the data-register byte of the result in the output stage.
// The buffer needs no clearing after reset and holds undefined contents until written.
module i2c_master_transfer_sequencer_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  i2cms_pkg::t_in_item   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output i2cms_pkg::t_out_item  o_out
);

    logic [7:0] mem [i2cms_pkg::BUFFER_DEPTH];

    logic                        r_busy;
    logic [6:0]                  r_target_addr;
    logic                        r_read_mode;
    logic [i2cms_pkg::POS_W-1:0] r_total_bytes;
    logic [i2cms_pkg::POS_W-1:0] r_cur_pos;
    logic                        r_ack_enable;

    logic                        n_busy;
    logic [6:0]                  n_target_addr;
    logic                        n_read_mode;
    logic [i2cms_pkg::POS_W-1:0] n_total_bytes;
    logic [i2cms_pkg::POS_W-1:0] n_cur_pos;
    logic                        n_ack_enable;

    logic                         r_out_valid;
    i2cms_pkg::t_out_item         r_res;
    logic                         r_dr_from_mem;
    logic [7:0]                   r_rd_data;

    i2cms_pkg::t_out_item         res;
    logic                         dr_from_mem;
    logic [i2cms_pkg::ADDR_W-1:0] rd_addr;
    logic                         mem_we;
    logic [i2cms_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                   wr_data;
    logic                         accept;
    logic [7:0]                   left;
    logic [i2cms_pkg::POS_W-1:0]  pos_inc;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign pos_inc     = r_cur_pos + i2cms_pkg::POS_W'(1);
    assign left        = 8'(r_total_bytes) - 8'(pos_inc);

    always_comb begin
        n_busy        = r_busy;
        n_target_addr = r_target_addr;
        n_read_mode   = r_read_mode;
        n_total_bytes = r_total_bytes;
        n_cur_pos     = r_cur_pos;
        n_ack_enable  = r_ack_enable;
        res           = '0;
        res.error_code = i2cms_pkg::ERR_NONE;
        dr_from_mem   = 1'b0;
        rd_addr       = i2cms_pkg::ADDR_W'(r_cur_pos);
        mem_we        = 1'b0;
        wr_addr       = i2cms_pkg::ADDR_W'(i_in.byte_index);
        wr_data       = i_in.data_byte;
        case (i_in.func)
            i2cms_pkg::FUNC_LOAD: begin
                if (!r_busy && (i2cms_pkg::CALC_W'(i_in.byte_index)
                                < i2cms_pkg::CALC_W'(i2cms_pkg::BUFFER_DEPTH))) begin
                    mem_we = 1'b1;
                end
            end
            i2cms_pkg::FUNC_START: begin
                if ((i2cms_pkg::CALC_W'(i_in.byte_count)
                     > i2cms_pkg::CALC_W'(i2cms_pkg::BUFFER_DEPTH)) || r_busy) begin
                    res.start_rejected = 1'b1;
                end else begin
                    n_busy        = 1'b1;
                    n_target_addr = i_in.dev_addr;
                    n_read_mode   = i_in.is_read;
                    n_total_bytes = i2cms_pkg::POS_W'(i_in.byte_count);
                    n_cur_pos     = '0;
                    n_ack_enable  = 1'b1;
                    res.start_req = 1'b1;
                end
            end
            i2cms_pkg::FUNC_EVENT: begin
                if (i_in.status_flags[i2cms_pkg::ST_START_SENT]) begin
                    res.dr_write = 1'b1;
                    res.dr_data  = {r_target_addr, r_read_mode};
                end else if (i_in.status_flags[i2cms_pkg::ST_ADDR]) begin
                    if (r_read_mode && (r_total_bytes == i2cms_pkg::POS_W'(1))) begin
                        n_ack_enable = 1'b0;
                    end
                    if (i_in.status_flags[i2cms_pkg::ST_TRANSMIT]) begin
                        res.dr_write = 1'b1;
                        dr_from_mem  = 1'b1;
                        rd_addr      = '0;
                        n_cur_pos    = pos_inc;
                    end else if (r_total_bytes == i2cms_pkg::POS_W'(1)) begin
                        res.stop_req = 1'b1;
                    end
                end else if (i_in.status_flags[i2cms_pkg::ST_TX_EMPTY]) begin
                    if (r_cur_pos < r_total_bytes) begin
                        res.dr_write = 1'b1;
                        dr_from_mem  = 1'b1;
                        n_cur_pos    = pos_inc;
                    end else if (i_in.status_flags[i2cms_pkg::ST_BYTE_DONE]) begin
                        res.stop_req = 1'b1;
                        res.op_done  = 1'b1;
                        n_busy       = 1'b0;
                    end
                end else if (i_in.status_flags[i2cms_pkg::ST_RX_FULL]) begin
                    if (i2cms_pkg::CALC_W'(r_cur_pos)
                        < i2cms_pkg::CALC_W'(i2cms_pkg::BUFFER_DEPTH)) begin
                        mem_we       = 1'b1;
                        wr_addr      = i2cms_pkg::ADDR_W'(r_cur_pos);
                        res.rx_valid = 1'b1;
                        res.rx_data  = i_in.data_byte;
                        res.rx_index = 4'(r_cur_pos);
                        n_cur_pos    = pos_inc;
                        if (left[7:0] == 8'd1) begin
                            n_ack_enable = 1'b0;
                            res.stop_req = 1'b1;
                        end else if (left[7:0] == 8'd0) begin
                            n_busy      = 1'b0;
                            res.op_done = 1'b1;
                        end
                    end
                end
            end
            i2cms_pkg::FUNC_ERROR: begin
                if (i_in.status_flags[i2cms_pkg::ST_ACK_FAIL]) begin
                    res.stop_req   = 1'b1;
                    res.start_req  = 1'b1;
                    res.error_code = i2cms_pkg::ERR_ACK_FAIL;
                    n_busy         = 1'b0;
                    n_ack_enable   = 1'b1;
                end else begin
                    res.error_code = i2cms_pkg::ERR_BUS;
                end
            end
            default: begin
                res.error_code = i2cms_pkg::ERR_NONE;
            end
        endcase
        res.ack_bit  = n_ack_enable;
        res.busy_res = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_target_addr <= '0;
            r_read_mode   <= 1'b0;
            r_total_bytes <= '0;
            r_cur_pos     <= '0;
            r_ack_enable  <= 1'b1;
        end else if (accept) begin
            r_busy        <= n_busy;
            r_target_addr <= n_target_addr;
            r_read_mode   <= n_read_mode;
            r_total_bytes <= n_total_bytes;
            r_cur_pos     <= n_cur_pos;
            r_ack_enable  <= n_ack_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res         <= res;
            r_dr_from_mem <= dr_from_mem;
        end
    end

    always_comb begin
        o_out = r_res;
        if (r_dr_from_mem) begin
            o_out.dr_data = r_rd_data;
        end
    end

    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted transaction did not reach the output register");

    a_stalled_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result was dropped");

    a_mem_read_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_dr_from_mem) |-> r_res.dr_write)
        else $error("buffer byte selected without a data-register write");

    a_rx_excludes_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.rx_valid) |-> !o_out.dr_write)
        else $error("receive and transmit in one result");

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.func == i2cms_pkg::FUNC_START) && !res.start_rejected)
        |=> r_busy)
        else $error("granted start did not set busy");

endmodule

>>> sim/i2c_master_transfer_sequencer_unit_tb.sv
// Self-checking testbench of the I2C master transfer sequencer with directed and random traffic.
module i2c_master_transfer_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cms_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1250;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item want;
    } t_tb_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;

    // Shadow state of the sequencer, advanced once per accepted transaction.
    logic                    busy_q = 1'b0;
    logic [6:0]              addr_q = '0;
    logic                    rd_q = 1'b0;
    int                      total_q = 0;
    int                      pos_q = 0;
    logic                    ack_q = 1'b1;
    logic [7:0]              mem_q [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] written_q = '0;

    t_out_item   pending_results [$];
    t_tb_row     rows [$];
    int          n_err = 0;
    int          n_sent = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    logic [31:0] stall_cyc = '0;

    i2c_master_transfer_sequencer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_in_item mk(t_func f, logic [6:0] a, logic rd, logic [7:0] cnt,
                                    logic [7:0] d, logic [3:0] idx, logic [6:0] st);
        t_in_item it;
        it.func = f;
        it.dev_addr = a;
        it.is_read = rd;
        it.byte_count = cnt;
        it.data_byte = d;
        it.byte_index = idx;
        it.status_flags = st;
        return it;
    endfunction

    function automatic t_out_item res(logic drw, logic [7:0] drd, logic sreq, logic preq,
                                      logic ack, logic busy, logic done, logic rej, t_err err);
        t_out_item r;
        r = '0;
        r.dr_write = drw;
        r.dr_data = drd;
        r.start_req = sreq;
        r.stop_req = preq;
        r.ack_bit = ack;
        r.busy_res = busy;
        r.op_done = done;
        r.start_rejected = rej;
        r.error_code = err;
        return r;
    endfunction

    function automatic t_in_item rnd_item();
        logic [63:0] raw;
        t_in_item    it;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        return it;
    endfunction

    function automatic int pick_count();
        if ($urandom_range(0, 4) != 0) begin
            return $urandom_range(0, 4);
        end
        return $urandom_range(5, BUFFER_DEPTH);
    endfunction

    // Turns a bus event that would fetch a never-written buffer entry into a plain
    // bus error.
    function automatic t_in_item guard_item(t_in_item it);
        int idx;
        idx = -1;
        if (it.func == FUNC_EVENT && !it.status_flags[ST_START_SENT]) begin
            if (it.status_flags[ST_ADDR]) begin
                if (it.status_flags[ST_TRANSMIT]) begin
                    idx = 0;
                end
            end else if (it.status_flags[ST_TX_EMPTY] && pos_q < total_q) begin
                idx = pos_q;
            end
        end
        if (idx >= 0 && (idx >= BUFFER_DEPTH || !written_q[idx])) begin
            it.func = FUNC_ERROR;
            it.status_flags[ST_ACK_FAIL] = 1'b0;
        end
        return it;
    endfunction

    function automatic t_out_item sequencer_step(t_in_item it);
        t_out_item  r;
        logic [6:0] st;
        int         left;
        r = '0;
        st = it.status_flags;
        case (it.func)
            FUNC_LOAD: begin
                if (!busy_q) begin
                    mem_q[it.byte_index] = it.data_byte;
                    written_q[it.byte_index] = 1'b1;
                end
            end
            FUNC_START: begin
                if (it.byte_count > BUFFER_DEPTH || busy_q) begin
                    r.start_rejected = 1'b1;
                end else begin
                    busy_q = 1'b1;
                    addr_q = it.dev_addr;
                    rd_q = it.is_read;
                    total_q = it.byte_count;
                    pos_q = 0;
                    ack_q = 1'b1;
                    r.start_req = 1'b1;
                end
            end
            FUNC_EVENT: begin
                if (st[ST_START_SENT]) begin
                    r.dr_write = 1'b1;
                    r.dr_data = {addr_q, rd_q};
                end else if (st[ST_ADDR]) begin
                    if (rd_q && total_q == 1) begin
                        ack_q = 1'b0;
                    end
                    if (st[ST_TRANSMIT]) begin
                        r.dr_write = 1'b1;
                        r.dr_data = mem_q[0];
                        pos_q = (pos_q + 1) & 32'h0000_FFFF;
                    end else if (total_q == 1) begin
                        r.stop_req = 1'b1;
                    end
                end else if (st[ST_TX_EMPTY]) begin
                    if (pos_q < total_q) begin
                        r.dr_write = 1'b1;
                        r.dr_data = mem_q[pos_q];
                        pos_q++;
                    end else if (st[ST_BYTE_DONE]) begin
                        r.stop_req = 1'b1;
                        busy_q = 1'b0;
                        r.op_done = 1'b1;
                    end
                end else if (st[ST_RX_FULL]) begin
                    if (pos_q < BUFFER_DEPTH) begin
                        mem_q[pos_q] = it.data_byte;
                        written_q[pos_q] = 1'b1;
                        r.rx_valid = 1'b1;
                        r.rx_data = it.data_byte;
                        r.rx_index = 4'(pos_q);
                        pos_q++;
                        left = (total_q - pos_q) & 8'hFF;
                        if (left == 1) begin
                            ack_q = 1'b0;
                            r.stop_req = 1'b1;
                        end else if (left == 0) begin
                            busy_q = 1'b0;
                            r.op_done = 1'b1;
                        end
                    end
                end
            end
            FUNC_ERROR: begin
                if (st[ST_ACK_FAIL]) begin
                    r.stop_req = 1'b1;
                    busy_q = 1'b0;
                    r.error_code = ERR_ACK_FAIL;
                    ack_q = 1'b1;
                    r.start_req = 1'b1;
                end else begin
                    r.error_code = ERR_BUS;
                end
            end
        endcase
        r.ack_bit = ack_q;
        r.busy_res = busy_q;
        return r;
    endfunction

    function automatic void cmp_field(string name, int unsigned e, int unsigned a);
        if (e != a) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
            n_err++;
        end
    endfunction

    task automatic apply_item(input t_in_item it_in, input bit typed, input t_out_item want);
        t_in_item  it;
        t_out_item pred;
        int        gap;
        it = guard_item(it_in);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (o_in_stall);
        pred = sequencer_step(it);
        pending_results.push_back(typed ? want : pred);
        n_sent++;
        burst_left--;
    endtask

    task automatic abort_transfer();
        t_in_item it;
        it = rnd_item();
        it.func = FUNC_ERROR;
        it.status_flags[ST_ACK_FAIL] = 1'b1;
        apply_item(it, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        stall_cyc <= stall_cyc + 1;
        case (stall_cyc[10:9])
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 1) == 0);
            2'd2: i_out_stall <= (stall_cyc[2:0] < 3'd3);
            default: i_out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("Result transaction arrived with no transaction outstanding.");
                    n_err++;
                end else begin
                    exp_r = pending_results.pop_front();
                    cmp_field("dr_write", exp_r.dr_write, o_out.dr_write);
                    cmp_field("dr_data", exp_r.dr_data, o_out.dr_data);
                    cmp_field("start_req", exp_r.start_req, o_out.start_req);
                    cmp_field("stop_req", exp_r.stop_req, o_out.stop_req);
                    cmp_field("ack_bit", exp_r.ack_bit, o_out.ack_bit);
                    cmp_field("busy_res", exp_r.busy_res, o_out.busy_res);
                    cmp_field("op_done", exp_r.op_done, o_out.op_done);
                    cmp_field("start_rejected", exp_r.start_rejected, o_out.start_rejected);
                    cmp_field("error_code", exp_r.error_code, o_out.error_code);
                    cmp_field("rx_valid", exp_r.rx_valid, o_out.rx_valid);
                    cmp_field("rx_data", exp_r.rx_data, o_out.rx_data);
                    cmp_field("rx_index", exp_r.rx_index, o_out.rx_index);
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        t_in_item it;
        int       n;
        int       m;
        int       kind;

        rows.push_back('{mk(FUNC_ERROR, 7'h00, 1'b0, 8'h00, 8'h00, 4'h0, 7'h00), 1'b1,
                         res(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, ERR_BUS)});
        rows.push_back('{mk(FUNC_EVENT, 7'h00, 1'b0, 8'h00, 8'h00, 4'h0, 7'h00), 1'b1,
                         res(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, ERR_NONE)});
        rows.push_back('{mk(FUNC_EVENT, 7'h00, 1'b0, 8'h00, 8'h00, 4'h0, 7'h01), 1'b1,
                         res(1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, ERR_NONE)});
        rows.push_back('{mk(FUNC_START, 7'h12, 1'b0, 8'd17, 8'h00, 4'h0, 7'h00), 1'b1,
                         res(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, ERR_NONE)});
        rows.push_back('{mk(FUNC_START, 7'h7F, 1'b1, 8'hFF, 8'hFF, 4'hF, 7'h7F), 1'b1,
                         res(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, ERR_NONE)});
        rows.push_back('{mk(FUNC_LOAD, 7'h00, 1'b0, 8'h00, 8'hFF, 4'h0, 7'h00), 1'b0, '0});
        rows.push_back('{mk(FUNC_LOAD, 7'h7F, 1'b1, 8'hFF, 8'h00, 4'hF, 7'h7F), 1'b0, '0});
        rows.push_back('{mk(FUNC_LOAD, 7'h00, 1'b0, 8'h00, 8'hA5, 4'h1, 7'h00), 1'b0, '0});
        rows.push_back('{mk(FUNC_START, 7'h7F, 1'b0, 8'd2, 8'h00, 4'h0, 7'h00), 1'b1,
                         res(1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, ERR_NONE)});
        rows.push_back('{mk(FUNC_START, 7'h01, 1'b1, 8'd0, 8'h00, 4'h0, 7'h00), 1'b1,
                         res(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, ERR_NONE)});
        rows.push_back('{mk(FUNC_LOAD, 7'h00, 1'b0, 8'h00, 8'h5A, 4'h2, 7'h00), 1'b0, '0});
        rows.push_back('{mk(FUNC_EVENT, 7'h00, 1'b0, 8'h00, 8'h00, 4'h0, 7'h7F), 1'b0, '0});
        rows.push_back('{mk(FUNC_EVENT, 7'h00, 1'b0, 8'h00, 8'h00, 4'h0, 7'h06), 1'b0, '0});
        rows.push_back('{mk(FUNC_EVENT, 7'h00, 1'b0, 8'h00, 8'h00, 4'h0, 7'h08), 1'b0, '0});
        rows.push_back('{mk(FUNC_EVENT, 7'h00, 1'b0, 8'h00, 8'h00, 4'h0, 7'h18), 1'b0, '0});
        rows.push_back('{mk(FUNC_EVENT, 7'h00, 1'b0, 8'h00, 8'h00, 4'h0, 7'h08), 1'b0, '0});
        rows.push_back('{mk(FUNC_START, 7'h55, 1'b1, 8'd1, 8'h00, 4'h0, 7'h00), 1'b1,
                         res(1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, ERR_NONE)});
        rows.push_back('{mk(FUNC_EVENT, 7'h00, 1'b0, 8'h00, 8'h00, 4'h0, 7'h02), 1'b0, '0});
        rows.push_back('{mk(FUNC_EVENT, 7'h00, 1'b0, 8'h00, 8'h3C, 4'h0, 7'h20), 1'b0, '0});
        rows.push_back('{mk(FUNC_START, 7'h00, 1'b1, 8'd16, 8'h00, 4'h0, 7'h00), 1'b1,
                         res(1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, ERR_NONE)});
        rows.push_back('{mk(FUNC_EVENT, 7'h00, 1'b0, 8'h00, 8'h00, 4'h0, 7'h01), 1'b0, '0});
        rows.push_back('{mk(FUNC_ERROR, 7'h00, 1'b0, 8'h00, 8'h00, 4'h0, 7'h40), 1'b1,
                         res(1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ERR_ACK_FAIL)});
        rows.push_back('{mk(FUNC_START, 7'h2A, 1'b1, 8'd0, 8'h00, 4'h0, 7'h00), 1'b1,
                         res(1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, ERR_NONE)});
        rows.push_back('{mk(FUNC_EVENT, 7'h00, 1'b0, 8'h00, 8'h00, 4'h0, 7'h20), 1'b0, '0});
        rows.push_back('{mk(FUNC_ERROR, 7'h7F, 1'b1, 8'hFF, 8'hFF, 4'hF, 7'h7F), 1'b1,
                         res(1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ERR_ACK_FAIL)});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            apply_item(rows[i].stim, rows[i].typed, rows[i].want);
        end

        n_sent = 0;
        while (n_sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 8 && busy_q) begin
                abort_transfer();
            end
            if (kind < 4) begin
                n = pick_count();
                for (int i = 0; i < n; i++) begin
                    it = rnd_item();
                    it.func = FUNC_LOAD;
                    it.byte_index = 4'(i);
                    apply_item(it, 1'b0, '0);
                end
                it = rnd_item();
                it.func = FUNC_START;
                it.is_read = 1'b0;
                it.byte_count = 8'(n);
                apply_item(it, 1'b0, '0);
                it = rnd_item();
                it.func = FUNC_EVENT;
                it.status_flags[ST_START_SENT] = 1'b1;
                apply_item(it, 1'b0, '0);
                it = rnd_item();
                it.func = FUNC_EVENT;
                it.status_flags[2:0] = 3'b110;
                apply_item(it, 1'b0, '0);
                for (int i = 1; i < n; i++) begin
                    it = rnd_item();
                    it.func = FUNC_EVENT;
                    it.status_flags[3:0] = 4'b1000;
                    apply_item(it, 1'b0, '0);
                end
                if ($urandom_range(0, 9) == 0) begin
                    abort_transfer();
                end else begin
                    it = rnd_item();
                    it.func = FUNC_EVENT;
                    it.status_flags[4:0] = 5'b11000;
                    apply_item(it, 1'b0, '0);
                end
            end else if (kind < 8) begin
                n = pick_count();
                it = rnd_item();
                it.func = FUNC_START;
                it.is_read = 1'b1;
                it.byte_count = 8'(n);
                apply_item(it, 1'b0, '0);
                it = rnd_item();
                it.func = FUNC_EVENT;
                it.status_flags[ST_START_SENT] = 1'b1;
                apply_item(it, 1'b0, '0);
                it = rnd_item();
                it.func = FUNC_EVENT;
                it.status_flags[2:0] = 3'b010;
                apply_item(it, 1'b0, '0);
                m = (n == 0) ? $urandom_range(1, BUFFER_DEPTH + 4) : n;
                for (int i = 0; i < m; i++) begin
                    it = rnd_item();
                    it.func = FUNC_EVENT;
                    it.status_flags[3:0] = 4'b0000;
                    it.status_flags[ST_RX_FULL] = 1'b1;
                    apply_item(it, 1'b0, '0);
                end
                if (n == 0 || $urandom_range(0, 9) == 0) begin
                    abort_transfer();
                end
            end else begin
                m = $urandom_range(1, 4);
                for (int i = 0; i < m; i++) begin
                    apply_item(rnd_item(), 1'b0, '0);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/i2cms_pkg.sv
rtl/i2c_master_transfer_sequencer_unit.sv
sim/i2c_master_transfer_sequencer_unit_tb.sv
